@@ hdl/ps2ct_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2ct_pkg
// Shared types and constants of the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2ct_pkg;

   localparam int unsigned COORD_W = 12;
   localparam int unsigned BYTE_W  = 8;

   localparam int unsigned SYNC_BIT   = 3;
   localparam int unsigned X_OVF_BIT  = 6;
   localparam int unsigned Y_OVF_BIT  = 7;
   localparam int unsigned LEFT_BIT   = 0;
   localparam int unsigned RIGHT_BIT  = 1;

   localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd320;
   localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd200;
   localparam logic [COORD_W-1:0] POS_X_RESET  = 12'd160;
   localparam logic [COORD_W-1:0] POS_Y_RESET  = 12'd100;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_DROP,
      CMD_PACKET
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BYTE_W-1:0]   status;
      logic [BYTE_W-1:0]   dx;
      logic [BYTE_W-1:0]   dy;
   } cmd_type;

endpackage

@@ hdl/ps2ct_front.sv @@
// ----------------------------------------------------------------------------
// ps2ct_front
// Byte assembler: tracks the position within a packet and classifies each
// received byte as dropped, held or packet-completing.
// ----------------------------------------------------------------------------
module ps2ct_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 q_full,
   output logic                 q_push,
   output ps2ct_pkg::cmd_type   q_cmd
);

   typedef enum logic [1:0] {
      BYTE_STATUS,
      BYTE_X,
      BYTE_Y
   } pos_type;

   pos_type     pos_ff, pos_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  x_move_ff, x_move_in;
   logic        accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   always_comb begin
      pos_in       = pos_ff;
      status_in    = status_ff;
      x_move_in    = x_move_ff;
      q_cmd.kind   = ps2ct_pkg::CMD_HOLD;
      q_cmd.status = status_ff;
      q_cmd.dx     = x_move_ff;
      q_cmd.dy     = req_rx_byte;
      case (pos_ff)
         BYTE_STATUS: begin
            if (req_rx_byte[ps2ct_pkg::SYNC_BIT]) begin
               status_in = req_rx_byte;
               pos_in    = BYTE_X;
            end else begin
               q_cmd.kind = ps2ct_pkg::CMD_DROP;
            end
         end
         BYTE_X: begin
            x_move_in = req_rx_byte;
            pos_in    = BYTE_Y;
         end
         default: begin
            q_cmd.kind = ps2ct_pkg::CMD_PACKET;
            pos_in     = BYTE_STATUS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= BYTE_STATUS;
         status_ff <= '0;
         x_move_ff <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         status_ff <= status_in;
         x_move_ff <= x_move_in;
      end
   end

endmodule

@@ hdl/ps2ct_queue.sv @@
// ----------------------------------------------------------------------------
// ps2ct_queue
// Short command queue between the byte assembler and the cursor update.
// ----------------------------------------------------------------------------
module ps2ct_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ps2ct_pkg::cmd_type   push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output ps2ct_pkg::cmd_type   head_cmd
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ps2ct_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign valid    = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/ps2ct_back.sv @@
// ----------------------------------------------------------------------------
// ps2ct_back
// Cursor update: applies completed packets to the clamped position, latches
// buttons and holds the result register toward the response channel.
// ----------------------------------------------------------------------------
module ps2ct_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [11:0]          csr_wdata,
   input  logic                 q_valid,
   input  ps2ct_pkg::cmd_type   q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [11:0]          rsp_cursor_x,
   output logic [11:0]          rsp_cursor_y,
   output logic                 rsp_left_button,
   output logic                 rsp_right_button,
   output logic                 rsp_packet_done,
   output logic                 rsp_byte_dropped
);

   logic [11:0] width_ff, height_ff;
   logic [11:0] pos_x_ff, pos_x_in;
   logic [11:0] pos_y_ff, pos_y_in;
   logic        left_ff, right_ff;
   logic        valid_ff, done_ff, dropped_ff;
   logic [7:0]  dx, dy;
   logic [13:0] sum_x, sum_y;
   logic        is_packet;

   function automatic logic [11:0] clamp_axis(input logic [13:0] v, input logic [11:0] limit);
      logic [11:0] top;
      top = (limit == '0) ? '0 : limit - 1'b1;
      if (v[13]) begin
         clamp_axis = '0;
      end else if (v[12:0] > {1'b0, top}) begin
         clamp_axis = top;
      end else begin
         clamp_axis = v[11:0];
      end
   endfunction

   assign q_pop     = q_valid && (!valid_ff || rsp_ready);
   assign is_packet = (q_cmd.kind == ps2ct_pkg::CMD_PACKET);

   assign dx    = q_cmd.status[ps2ct_pkg::X_OVF_BIT] ? '0 : q_cmd.dx;
   assign dy    = q_cmd.status[ps2ct_pkg::Y_OVF_BIT] ? '0 : q_cmd.dy;
   assign sum_x = {2'b00, pos_x_ff} + {{6{dx[7]}}, dx};
   assign sum_y = {2'b00, pos_y_ff} - {{6{dy[7]}}, dy};
   assign pos_x_in = clamp_axis(sum_x, width_ff);
   assign pos_y_in = clamp_axis(sum_y, height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ps2ct_pkg::WIDTH_RESET;
         height_ff <= ps2ct_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ps2ct_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            ps2ct_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         done_ff    <= 1'b0;
         dropped_ff <= 1'b0;
         pos_x_ff   <= ps2ct_pkg::POS_X_RESET;
         pos_y_ff   <= ps2ct_pkg::POS_Y_RESET;
         left_ff    <= 1'b0;
         right_ff   <= 1'b0;
      end else if (q_pop) begin
         valid_ff   <= 1'b1;
         done_ff    <= is_packet;
         dropped_ff <= (q_cmd.kind == ps2ct_pkg::CMD_DROP);
         if (is_packet) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            left_ff  <= q_cmd.status[ps2ct_pkg::LEFT_BIT];
            right_ff <= q_cmd.status[ps2ct_pkg::RIGHT_BIT];
         end
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_cursor_x     = pos_x_ff;
   assign rsp_cursor_y     = pos_y_ff;
   assign rsp_left_button  = left_ff;
   assign rsp_right_button = right_ff;
   assign rsp_packet_done  = done_ff;
   assign rsp_byte_dropped = dropped_ff;

endmodule

@@ hdl/ps2_mouse_packet_cursor_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Path: an accepted byte is written as a command into the queue, and the result
// register takes the command from the queue head once it is free or being read.
// Throughput: one byte per cycle; the result register and the command queue
// decouple the response side from the request side; the input stalls only
// once the queue is full behind a held result.
// Reset: synchronous; cursor at 160,100, buttons clear, bounds 320 by 200,
// packet assembly restarts at the status byte.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_cursor_x,
   output logic [11:0] rsp_cursor_y,
   output logic        rsp_left_button,
   output logic        rsp_right_button,
   output logic        rsp_packet_done,
   output logic        rsp_byte_dropped
);

   ps2ct_pkg::cmd_type push_cmd, head_cmd;
   logic               push, pop, full, q_valid;

   ps2ct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   ps2ct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   ps2ct_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_valid          (q_valid),
      .q_cmd            (head_cmd),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_right_button (rsp_right_button),
      .rsp_packet_done  (rsp_packet_done),
      .rsp_byte_dropped (rsp_byte_dropped)
   );

endmodule

@@ hdl/ps2ct_checker.sv @@
// ----------------------------------------------------------------------------
// ps2ct_checker
// Port-level checks of the cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ps2ct_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_wr_en,
   input logic        csr_index,
   input logic [11:0] csr_wdata,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_cursor_x,
   input logic [11:0] rsp_cursor_y,
   input logic        rsp_left_button,
   input logic        rsp_right_button,
   input logic        rsp_packet_done,
   input logic        rsp_byte_dropped
);

   logic        seen_ff;
   logic [11:0] last_x_ff, last_y_ff;
   logic        last_left_ff, last_right_ff;
   logic        unused_in;

   assign unused_in = csr_wr_en ^ csr_index ^ (^csr_wdata) ^ req_valid ^ req_ready
                      ^ (^req_rx_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_x_ff     <= rsp_cursor_x;
         last_y_ff     <= rsp_cursor_y;
         last_left_ff  <= rsp_left_button;
         last_right_ff <= rsp_right_button;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_packet_done && rsp_byte_dropped) || unused_in != unused_in)
      else $error("packet done and byte dropped together");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_x)
         && $stable(rsp_cursor_y) && $stable(rsp_packet_done))
      else $error("stalled response changed");

   a_still_without_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff && !rsp_packet_done |-> rsp_cursor_x == last_x_ff
         && rsp_cursor_y == last_y_ff && rsp_left_button == last_left_ff
         && rsp_right_button == last_right_ff)
      else $error("cursor moved without a packet");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_x != 12'hFFF && rsp_cursor_y != 12'hFFF)
      else $error("cursor out of range");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2ct_checker u_ps2ct_checker (.*);
